// ===== design/aet_pkg.sv =====
`default_nettype none

package aet_pkg;

    localparam logic [7:0] LEVEL_MAX = 8'hFF;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ATTACK_STEP    = 3'd0;
    localparam logic [2:0] CFG_DECAY_FACTOR   = 3'd1;
    localparam logic [2:0] CFG_SUSTAIN_LEVEL  = 3'd2;
    localparam logic [2:0] CFG_RELEASE_FACTOR = 3'd3;
    localparam logic [2:0] CFG_ECHO_LEVEL     = 3'd4;
    localparam logic [2:0] CFG_ECHO_FRAMES    = 3'd5;
    localparam logic [2:0] CFG_MASTER_GAIN    = 3'd6;

    // Envelope stage of the voice.
    typedef enum logic [5:0] {
        ENV_IDLE    = 6'b000001,
        ENV_ATTACK  = 6'b000010,
        ENV_DECAY   = 6'b000100,
        ENV_SUSTAIN = 6'b001000,
        ENV_RELEASE = 6'b010000,
        ENV_ECHO    = 6'b100000
    } env_stage_t;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ENV   = 6'b000010,
        ST_SCALE = 6'b000100,
        ST_RIGHT = 6'b001000,
        ST_LEFT  = 6'b010000,
        ST_DONE  = 6'b100000
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic env_step;
        logic scale_step;
        logic right_step;
        logic left_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic sounds;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/aet_datapath.sv =====
`default_nettype none

module aet_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire aet_pkg::dp_cmd_t   cmd,
    output aet_pkg::dp_status_t     status,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [7:0]         cfg_wdata,
    input  wire logic               s_note_on,
    input  wire logic               s_note_off,
    input  wire logic [7:0]         s_right_gain,
    input  wire logic [7:0]         s_left_gain,
    output logic                    m_active,
    output logic [7:0]              m_level,
    output logic [7:0]              m_right_level,
    output logic [7:0]              m_left_level
);

    logic [7:0] attack_step_reg;
    logic [7:0] decay_factor_reg;
    logic [7:0] sustain_level_reg;
    logic [7:0] release_factor_reg;
    logic [7:0] echo_level_reg;
    logic [7:0] echo_frames_reg;
    logic [3:0] master_gain_reg;

    aet_pkg::env_stage_t stage_reg, stage_next, eff_stage;
    logic [7:0] level_reg;
    logic [7:0] echo_cnt_reg, echo_cnt_next;
    logic [7:0] right_held_reg;
    logic [7:0] left_held_reg;

    logic       on_reg, off_reg;
    logic [7:0] rg_reg, lg_reg;
    logic [7:0] v_reg, v_next;
    logic       sounds_reg, sounds_next;
    logic [7:0] scaled_reg;

    logic [7:0]  mul_a, mul_b;
    logic [15:0] prod;
    logic [7:0]  vm;
    logic [8:0]  attack_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_step_reg    <= 8'd255;
            decay_factor_reg   <= 8'd255;
            sustain_level_reg  <= 8'd255;
            release_factor_reg <= 8'd0;
            echo_level_reg     <= 8'd0;
            echo_frames_reg    <= 8'd0;
            master_gain_reg    <= 4'd15;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                aet_pkg::CFG_ATTACK_STEP:    attack_step_reg    <= cfg_wdata;
                aet_pkg::CFG_DECAY_FACTOR:   decay_factor_reg   <= cfg_wdata;
                aet_pkg::CFG_SUSTAIN_LEVEL:  sustain_level_reg  <= cfg_wdata;
                aet_pkg::CFG_RELEASE_FACTOR: release_factor_reg <= cfg_wdata;
                aet_pkg::CFG_ECHO_LEVEL:     echo_level_reg     <= cfg_wdata;
                aet_pkg::CFG_ECHO_FRAMES:    echo_frames_reg    <= cfg_wdata;
                aet_pkg::CFG_MASTER_GAIN:    master_gain_reg    <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // One shared 8x8 multiplier; each step uses it once.
    always_comb begin
        priority if (cmd.env_step) begin
            mul_a = level_reg;
            mul_b = (eff_stage == aet_pkg::ENV_RELEASE) ? release_factor_reg
                                                        : decay_factor_reg;
        end else if (cmd.scale_step) begin
            mul_a = v_reg;
            mul_b = {4'd0, master_gain_reg} + 8'd1;
        end else if (cmd.right_step) begin
            mul_a = rg_reg;
            mul_b = scaled_reg;
        end else begin
            mul_a = lg_reg;
            mul_b = scaled_reg;
        end
    end

    assign prod       = mul_a * mul_b;
    assign vm         = prod[15:8];
    assign attack_sum = {1'b0, level_reg} + {1'b0, attack_step_reg};

    always_comb begin
        eff_stage = stage_reg;
        if (off_reg && (stage_reg == aet_pkg::ENV_ATTACK || stage_reg == aet_pkg::ENV_DECAY
                        || stage_reg == aet_pkg::ENV_SUSTAIN)) begin
            eff_stage = aet_pkg::ENV_RELEASE;
        end
    end

    always_comb begin
        stage_next    = eff_stage;
        v_next        = level_reg;
        sounds_next   = 1'b1;
        echo_cnt_next = echo_cnt_reg;
        if (on_reg) begin
            if (off_reg) begin
                stage_next  = aet_pkg::ENV_IDLE;
                sounds_next = 1'b0;
            end else begin
                echo_cnt_next = echo_frames_reg;
                v_next        = attack_step_reg;
                stage_next    = aet_pkg::ENV_ATTACK;
                if (attack_step_reg == aet_pkg::LEVEL_MAX) begin
                    stage_next = aet_pkg::ENV_DECAY;
                end
            end
        end else begin
            unique case (eff_stage)
                aet_pkg::ENV_ATTACK: begin
                    if (attack_sum >= {1'b0, aet_pkg::LEVEL_MAX}) begin
                        v_next     = aet_pkg::LEVEL_MAX;
                        stage_next = aet_pkg::ENV_DECAY;
                    end else begin
                        v_next = attack_sum[7:0];
                    end
                end
                aet_pkg::ENV_DECAY: begin
                    v_next = vm;
                    if (vm <= sustain_level_reg) begin
                        v_next     = sustain_level_reg;
                        stage_next = aet_pkg::ENV_SUSTAIN;
                        if (sustain_level_reg == 8'd0) begin
                            v_next     = echo_level_reg;
                            stage_next = aet_pkg::ENV_ECHO;
                            if (echo_level_reg == 8'd0) begin
                                stage_next  = aet_pkg::ENV_IDLE;
                                sounds_next = 1'b0;
                            end
                        end
                    end
                end
                aet_pkg::ENV_SUSTAIN: begin
                end
                aet_pkg::ENV_RELEASE: begin
                    v_next = vm;
                    if (vm <= echo_level_reg) begin
                        v_next     = echo_level_reg;
                        stage_next = aet_pkg::ENV_ECHO;
                        if (echo_level_reg == 8'd0) begin
                            stage_next  = aet_pkg::ENV_IDLE;
                            sounds_next = 1'b0;
                        end
                    end
                end
                aet_pkg::ENV_ECHO: begin
                    echo_cnt_next = echo_cnt_reg - 8'd1;
                    if (echo_cnt_reg <= 8'd1) begin
                        stage_next  = aet_pkg::ENV_IDLE;
                        sounds_next = 1'b0;
                    end
                end
                default: begin
                    stage_next  = aet_pkg::ENV_IDLE;
                    sounds_next = 1'b0;
                end
            endcase
        end
    end

    assign status.sounds = sounds_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg      <= aet_pkg::ENV_IDLE;
            level_reg      <= 8'd0;
            echo_cnt_reg   <= 8'd0;
            right_held_reg <= 8'd0;
            left_held_reg  <= 8'd0;
        end else begin
            if (cmd.env_step) begin
                stage_reg    <= stage_next;
                echo_cnt_reg <= echo_cnt_next;
            end
            if (cmd.scale_step) begin
                level_reg <= v_reg;
            end
            if (cmd.right_step) begin
                right_held_reg <= prod[15:8];
            end
            if (cmd.left_step) begin
                left_held_reg <= prod[15:8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            on_reg  <= s_note_on;
            off_reg <= s_note_off;
            rg_reg  <= s_right_gain;
            lg_reg  <= s_left_gain;
        end
        if (cmd.env_step) begin
            v_reg      <= v_next;
            sounds_reg <= sounds_next;
        end
        if (cmd.scale_step) begin
            scaled_reg <= prod[11:4];
        end
        if (cmd.out_load) begin
            m_active      <= sounds_reg;
            m_level       <= level_reg;
            m_right_level <= right_held_reg;
            m_left_level  <= left_held_reg;
        end
    end

endmodule

`default_nettype wire

// ===== design/aet_ctrl.sv =====
`default_nettype none

module aet_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire aet_pkg::dp_status_t status,
    output aet_pkg::dp_cmd_t         cmd
);

    aet_pkg::ctrl_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == aet_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd            = '0;
        unique case (state_reg)
            aet_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = aet_pkg::ST_ENV;
                end
            end
            aet_pkg::ST_ENV: begin
                cmd.env_step = 1'b1;
                state_next   = status.sounds ? aet_pkg::ST_SCALE : aet_pkg::ST_DONE;
            end
            aet_pkg::ST_SCALE: begin
                cmd.scale_step = 1'b1;
                state_next     = aet_pkg::ST_RIGHT;
            end
            aet_pkg::ST_RIGHT: begin
                cmd.right_step = 1'b1;
                state_next     = aet_pkg::ST_LEFT;
            end
            aet_pkg::ST_LEFT: begin
                cmd.left_step = 1'b1;
                state_next    = aet_pkg::ST_DONE;
            end
            aet_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = aet_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = aet_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= aet_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while a result waits");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == aet_pkg::ST_ENV))
        else $error("accepted request did not start the envelope step");

    a_silent_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.env_step && !status.sounds) |=> (state_reg == aet_pkg::ST_DONE))
        else $error("silent frame entered the scaling steps");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== design/adsr_envelope_with_echo_tail.sv =====
// Envelope generator for one voice, advanced once per frame request.
// Input channel (s_valid/s_ready): one request per frame carrying note-on,
// note-off and the right and left side volumes. Result channel
// (m_valid/m_ready): exactly one result per request with the active flag,
// the envelope level and the right and left output volumes.
// Configuration is a plain write port: cfg_wr_en, cfg_index and cfg_wdata
// write one register per cycle; indexes beyond the last register are ignored.
// A request is taken in the idle state. A sounding frame then runs the
// envelope, scale, right and left steps and is loaded in the done state; a
// silent frame goes from the envelope step straight to done. A request is
// taken only after the last result is loaded. The steps follow from the
// single shared 8x8 multiplier, used in turn for the decay or release
// factor, the master gain and the two side volumes.
// Reset (aresetn, synchronous, active low) puts the voice in idle with a zero
// level and loads the configuration defaults.
// When the receiver stalls, the finished result stays in the output register;
// the next request is still taken and computed, and then waits until the
// output register frees up.
`default_nettype none

module adsr_envelope_with_echo_tail (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_note_on,
    input  wire logic       s_note_off,
    input  wire logic [7:0] s_right_gain,
    input  wire logic [7:0] s_left_gain,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_active,
    output logic [7:0]      m_level,
    output logic [7:0]      m_right_level,
    output logic [7:0]      m_left_level
);

    // Commands from the sequencer and the datapath's verdict on whether the
    // frame sounds.
    aet_pkg::dp_cmd_t    cmd;
    aet_pkg::dp_status_t status;

    aet_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the configuration, the envelope state, the shared
    // multiplier and the output register.
    aet_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_note_on     (s_note_on),
        .s_note_off    (s_note_off),
        .s_right_gain  (s_right_gain),
        .s_left_gain   (s_left_gain),
        .m_active      (m_active),
        .m_level       (m_level),
        .m_right_level (m_right_level),
        .m_left_level  (m_left_level)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The write port has room for eight registers; the last index has no register
    // behind it, and a write there must leave the voice untouched.
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // The run is cut off here.
    localparam int CYCLE_LIMIT = 400000;

    // One frame request as the sender drives it, and the result that the voice
    // should return for it.
    typedef struct packed {
        logic       on;
        logic       off;
        logic [7:0] right_gain;
        logic [7:0] left_gain;
    } frame_req_t;

    typedef struct packed {
        logic       active;
        logic [7:0] level;
        logic [7:0] right;
        logic [7:0] left;
    } frame_out_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = 3'd0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_note_on = 1'b0;
    logic       s_note_off = 1'b0;
    logic [7:0] s_right_gain = 8'd0;
    logic [7:0] s_left_gain = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_active;
    logic [7:0] m_level;
    logic [7:0] m_right_level;
    logic [7:0] m_left_level;

    adsr_envelope_with_echo_tail dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_note_on     (s_note_on),
        .s_note_off    (s_note_off),
        .s_right_gain  (s_right_gain),
        .s_left_gain   (s_left_gain),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_active      (m_active),
        .m_level       (m_level),
        .m_right_level (m_right_level),
        .m_left_level  (m_left_level)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Shadow copy of the configuration registers, updated as each write is issued.
    logic [7:0] attack_step_r;
    logic [7:0] decay_factor_r;
    logic [7:0] sustain_level_r;
    logic [7:0] release_factor_r;
    logic [7:0] echo_level_r;
    logic [7:0] echo_frames_r;
    logic [3:0] master_gain_r;

    // Shadow copy of the voice state that the predictor advances per request.
    aet_pkg::env_stage_t voice_stage;
    logic [7:0] voice_level;
    logic [7:0] tail_count;
    logic [7:0] right_hold;
    logic [7:0] left_hold;

    // Requests waiting for the sender, and results still owed by the voice.
    frame_req_t frame_backlog[$];
    frame_out_t frames_due[$];

    frame_req_t held_req;
    frame_out_t want;
    int         queued_count = 0;
    int         sent_count = 0;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         gap_left = 0;
    int         burst_left = 0;
    int         ready_left = 0;
    int         phase;
    // When clear, the sender streams back to back and the receiver never stalls.
    bit         throttle = 1'b1;

    // Stores a new envelope level and derives the two side volumes from it. The
    // master gain scales by (gain + 1) / 16 first, then each side gain by 1/256.
    function automatic void load_level(input int unsigned v, input logic [7:0] rg,
                                       input logic [7:0] lg);
        int unsigned scaled;
        int unsigned side;
        voice_level = v[7:0];
        scaled = ((master_gain_r + 1) * voice_level) >> 4;
        side = (rg * scaled) >> 8;
        right_hold = side[7:0];
        side = (lg * scaled) >> 8;
        left_hold = side[7:0];
    endfunction

    // Advances the voice by one frame and returns the result that the frame owes.
    // A silent frame leaves the level and both side volumes as they were.
    function automatic frame_out_t advance_envelope(input frame_req_t r);
        frame_out_t  o;
        logic        sounds;
        int unsigned v;
        logic [7:0]  remain;
        sounds = 1'b1;
        v = voice_level;
        if (r.on) begin
            if (r.off) begin
                // Both requests in one frame cancel the note outright.
                voice_stage = aet_pkg::ENV_IDLE;
                sounds = 1'b0;
            end else begin
                // A note-on restarts from any stage; a full attack step skips
                // straight to decay.
                tail_count = echo_frames_r;
                v = attack_step_r;
                voice_stage = aet_pkg::ENV_ATTACK;
                if (v >= aet_pkg::LEVEL_MAX) begin
                    v = aet_pkg::LEVEL_MAX;
                    voice_stage = aet_pkg::ENV_DECAY;
                end
                load_level(v, r.right_gain, r.left_gain);
            end
        end else if (voice_stage == aet_pkg::ENV_IDLE) begin
            sounds = 1'b0;
        end else begin
            // A note-off moves any sounding stage but the tail into release, and
            // release is already applied in this frame.
            if (r.off && voice_stage != aet_pkg::ENV_ECHO) begin
                voice_stage = aet_pkg::ENV_RELEASE;
            end
            unique case (voice_stage)
                aet_pkg::ENV_ECHO: begin
                    remain = tail_count;
                    tail_count = remain - 8'd1;
                    if (remain <= 8'd1) begin
                        voice_stage = aet_pkg::ENV_IDLE;
                        sounds = 1'b0;
                    end
                end
                aet_pkg::ENV_RELEASE: begin
                    v = (v * release_factor_r) >> 8;
                    if (v <= echo_level_r) begin
                        v = echo_level_r;
                        if (v == 0) begin
                            voice_stage = aet_pkg::ENV_IDLE;
                            sounds = 1'b0;
                        end else begin
                            voice_stage = aet_pkg::ENV_ECHO;
                        end
                    end
                end
                aet_pkg::ENV_DECAY: begin
                    v = (v * decay_factor_r) >> 8;
                    if (v <= sustain_level_r) begin
                        v = sustain_level_r;
                        if (v == 0) begin
                            // A zero sustain drops straight into the tail.
                            v = echo_level_r;
                            if (v == 0) begin
                                voice_stage = aet_pkg::ENV_IDLE;
                                sounds = 1'b0;
                            end else begin
                                voice_stage = aet_pkg::ENV_ECHO;
                            end
                        end else begin
                            voice_stage = aet_pkg::ENV_SUSTAIN;
                        end
                    end
                end
                aet_pkg::ENV_ATTACK: begin
                    v = v + attack_step_r;
                    if (v >= aet_pkg::LEVEL_MAX) begin
                        v = aet_pkg::LEVEL_MAX;
                        voice_stage = aet_pkg::ENV_DECAY;
                    end
                end
                default: begin
                end
            endcase
            if (sounds) begin
                load_level(v, r.right_gain, r.left_gain);
            end
        end
        o.active = sounds;
        o.level = voice_level;
        o.right = right_hold;
        o.left = left_hold;
        return o;
    endfunction

    task automatic queue_request(input logic on, input logic off, input logic [7:0] rg,
                                 input logic [7:0] lg);
        frame_req_t r;
        r.on = on;
        r.off = off;
        r.right_gain = rg;
        r.left_gain = lg;
        frame_backlog.push_back(r);
        queued_count++;
    endtask

    task automatic queue_random(input logic on, input logic off);
        queue_request(on, off, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Blocks until every request has gone out and every result has come back, and
    // then lets the pipeline settle.
    task automatic wait_for_drain();
        while (frame_backlog.size() != 0 || s_valid || frames_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        unique case (idx)
            aet_pkg::CFG_ATTACK_STEP:    attack_step_r = val;
            aet_pkg::CFG_DECAY_FACTOR:   decay_factor_r = val;
            aet_pkg::CFG_SUSTAIN_LEVEL:  sustain_level_r = val;
            aet_pkg::CFG_RELEASE_FACTOR: release_factor_r = val;
            aet_pkg::CFG_ECHO_LEVEL:     echo_level_r = val;
            aet_pkg::CFG_ECHO_FRAMES:    echo_frames_r = val;
            aet_pkg::CFG_MASTER_GAIN:    master_gain_r = val[3:0];
            default: begin
            end
        endcase
    endtask

    // Reprograms the whole voice once all traffic has drained. Every call also
    // writes the unused index with a random value, which must change nothing.
    task automatic set_voice(input logic [7:0] atk, input logic [7:0] dec,
                             input logic [7:0] sus, input logic [7:0] rel,
                             input logic [7:0] elev, input logic [7:0] efr,
                             input logic [7:0] gain);
        wait_for_drain();
        write_reg(aet_pkg::CFG_ATTACK_STEP, atk);
        write_reg(aet_pkg::CFG_DECAY_FACTOR, dec);
        write_reg(aet_pkg::CFG_SUSTAIN_LEVEL, sus);
        write_reg(aet_pkg::CFG_RELEASE_FACTOR, rel);
        write_reg(aet_pkg::CFG_ECHO_LEVEL, elev);
        write_reg(aet_pkg::CFG_ECHO_FRAMES, efr);
        write_reg(aet_pkg::CFG_MASTER_GAIN, gain);
        write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Favors the two ends of the byte range.
    function automatic logic [7:0] pick_byte();
        unique case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Most of the random traffic is whole notes: a note-on, some frames, usually
    // a note-off and then up to 14 further frames for release and the tail. The
    // rest is noise with any mix of the two request bits, which also lands
    // note-offs in release and the tail and note-ons in every stage.
    task automatic random_notes(input int n);
        int target;
        int kind;
        int hold;
        int tail;
        target = queued_count + n;
        while (queued_count < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                queue_random(1'b1, 1'b0);
                hold = $urandom_range(0, 12);
                repeat (hold) queue_random(1'b0, 1'b0);
                if (kind != 0) begin
                    queue_random(1'b0, 1'b1);
                    tail = $urandom_range(0, 14);
                    repeat (tail) queue_random(1'b0, 1'b0);
                end
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    queue_random(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    // Sender. It offers requests from the backlog in bursts of random length with
    // random gaps between them. A request is predicted the moment it is taken.
    // Every 97th request makes the sender hold back until the voice has returned
    // every result owed, so the block also sees a fully drained pipeline mid-run.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                frames_due.push_back(advance_envelope(held_req));
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (frame_backlog.size() != 0 &&
                             !(sent_count != 0 && sent_count % 97 == 0 &&
                               frames_due.size() != 0)) begin
                    held_req = frame_backlog.pop_front();
                    s_valid <= 1'b1;
                    s_note_on <= held_req.on;
                    s_note_off <= held_req.off;
                    s_right_gain <= held_req.right_gain;
                    s_left_gain <= held_req.left_gain;
                    sent_count++;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        if (throttle && $urandom_range(0, 2) != 0) begin
                            gap_left = $urandom_range(1, 11);
                        end else begin
                            gap_left = 0;
                        end
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. It alternates runs of ready and stall cycles of random length,
    // independent of what the sender is doing.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_left = 0;
        end else if (!throttle) begin
            m_ready <= 1'b1;
        end else if (ready_left != 0) begin
            ready_left--;
        end else if (m_ready) begin
            m_ready <= 1'b0;
            ready_left = $urandom_range(0, 9);
        end else begin
            m_ready <= 1'b1;
            ready_left = $urandom_range(0, 15);
        end
    end

    // Reports a wrong field and counts it.
    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
        if (exp_val !== got_val) begin
            fail_count++;
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
        end
    endtask

    // Monitor. Each result taken is held against the oldest one still owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                fail_count++;
                $error("result returned with no request outstanding");
            end else begin
                want = frames_due.pop_front();
                check_field("active", 8'(want.active), 8'(m_active));
                check_field("level", want.level, m_level);
                check_field("right_level", want.right, m_right_level);
                check_field("left_level", want.left, m_left_level);
            end
        end
    end

    // Watchdog for a hung handshake or a result that never comes.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("adsr_envelope_with_echo_tail regression: fail");
        $finish;
    end

    initial begin
        attack_step_r = 8'd255;
        decay_factor_r = 8'd255;
        sustain_level_r = 8'd255;
        release_factor_r = 8'd0;
        echo_level_r = 8'd0;
        echo_frames_r = 8'd0;
        master_gain_r = 4'd15;
        voice_stage = aet_pkg::ENV_IDLE;
        voice_level = 8'd0;
        tail_count = 8'd0;
        right_hold = 8'd0;
        left_hold = 8'd0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration. A note-off on an idle voice is ignored, a full
        // attack step jumps to decay, and the first decay frame lands on the full
        // sustain level. Note-on with note-off silences the voice, and a release
        // factor of zero with no tail ends the note at once.
        queue_request(1'b0, 1'b1, 8'hFF, 8'hFF);
        queue_request(1'b1, 1'b0, 8'hFF, 8'hFF);
        queue_request(1'b0, 1'b0, 8'h00, 8'h00);
        queue_request(1'b1, 1'b1, 8'hAA, 8'h55);
        queue_request(1'b1, 1'b0, 8'h80, 8'h01);
        queue_request(1'b0, 1'b1, 8'h5A, 8'hA5);

        // A complete note: two attack frames saturating into decay, decay down
        // to sustain, release entered in the note-off frame, then a two-frame
        // tail in which a note-off is ignored.
        set_voice(8'd100, 8'd128, 8'd80, 8'd128, 8'd20, 8'd2, 8'd7);
        queue_request(1'b1, 1'b0, 8'h33, 8'hCC);
        queue_random(1'b0, 1'b0);
        queue_random(1'b0, 1'b0);
        queue_random(1'b0, 1'b0);
        queue_random(1'b0, 1'b0);
        queue_random(1'b0, 1'b0);
        queue_random(1'b0, 1'b1);
        queue_random(1'b0, 1'b0);
        queue_random(1'b0, 1'b0);
        queue_random(1'b0, 1'b1);
        queue_random(1'b0, 1'b0);

        // A zero attack step holds the level; release at zero falls into a
        // one-frame tail. The gain write carries upper bits that must be dropped.
        set_voice(8'd0, 8'd128, 8'd0, 8'd255, 8'd30, 8'd1, 8'hF3);
        queue_random(1'b1, 1'b0);
        queue_random(1'b0, 1'b0);
        queue_random(1'b0, 1'b1);
        queue_random(1'b0, 1'b0);

        // Decay runs down to a zero sustain, which starts the tail directly. A
        // tail length of zero ends the voice on its first tail frame.
        set_voice(8'd255, 8'd64, 8'd0, 8'd200, 8'd30, 8'd0, 8'd15);
        queue_random(1'b1, 1'b0);
        repeat (5) queue_random(1'b0, 1'b0);

        // Random notes over a range of settings, the all-zero and all-ones
        // corners first. One phase runs with neither side idling at all.
        for (phase = 0; phase < 7; phase++) begin
            unique case (phase)
                0: set_voice(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                1: set_voice(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                default: begin
                    set_voice(pick_byte(),
                              ($urandom_range(0, 3) == 0) ? pick_byte()
                                                          : 8'($urandom_range(150, 250)),
                              pick_byte(),
                              ($urandom_range(0, 3) == 0) ? pick_byte()
                                                          : 8'($urandom_range(150, 250)),
                              pick_byte(),
                              ($urandom_range(0, 3) == 0) ? pick_byte()
                                                          : 8'($urandom_range(0, 5)),
                              8'($urandom_range(0, 255)));
                end
            endcase
            throttle = (phase != 3);
            random_notes(100);
        end

        wait_for_drain();
        if (fail_count == 0) begin
            $display("adsr_envelope_with_echo_tail regression: pass");
        end else begin
            $display("adsr_envelope_with_echo_tail regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
